// ===== src/sbfp_pkg.sv =====
// Shared types and constants for the serial-bus frame parser.
`timescale 1ns / 1ps
`default_nettype none

package sbfp_pkg;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_DATA = 3'b010,
		PH_END  = 3'b100
	} phase_t;

	localparam logic [1:0] RT_CHAN  = 2'd0;
	localparam logic [1:0] RT_FLAGS = 2'd1;
	localparam logic [1:0] RT_GOOD  = 2'd2;
	localparam logic [1:0] RT_ERROR = 2'd3;

	localparam logic CFG_START_MARKER = 1'b0;
	localparam logic CFG_END_MARKER   = 1'b1;

	localparam logic [7:0] START_MARKER_RST = 8'hF0;
	localparam logic [7:0] END_MARKER_RST   = 8'h00;

	localparam logic [4:0] DATA_BYTES = 5'd22;
	localparam logic [4:0] CH_BITS    = 5'd11;

	typedef struct packed {
		phase_t     phase;
		logic [4:0] byte_count;
		logic [9:0] pend_bits;
		logic [3:0] pend_count;
		logic [3:0] next_chan;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  rtype;
		logic [3:0]  idx;
		logic [10:0] value;
		logic [1:0]  flags;
	} result_t;

endpackage

`default_nettype wire

// ===== src/sbfp_step.sv =====
// Per-byte parse step: next state and optional result for one received byte.
`timescale 1ns / 1ps
`default_nettype none

module sbfp_step (
	input  var sbfp_pkg::parse_state_t cur,
	input  wire logic [7:0]            data_byte,
	input  wire logic [7:0]            start_marker,
	input  wire logic [7:0]            end_marker,
	output var sbfp_pkg::parse_state_t nxt,
	output var sbfp_pkg::result_t      res
);
	import sbfp_pkg::*;

	logic [22:0] acc;
	logic [4:0]  cnt;
	logic [4:0]  cnt_left;

	assign acc      = {13'd0, cur.pend_bits} | ({15'd0, data_byte} << cur.pend_count);
	assign cnt      = {1'b0, cur.pend_count} + 5'd8;
	assign cnt_left = cnt - CH_BITS;

	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			PH_DATA: begin
				nxt.byte_count = cur.byte_count + 5'd1;
				if (cur.byte_count < DATA_BYTES) begin
					if (cnt >= CH_BITS) begin
						res.valid      = 1'b1;
						res.rtype      = RT_CHAN;
						res.idx        = cur.next_chan;
						res.value      = acc[10:0];
						nxt.pend_bits  = acc[20:11];
						nxt.pend_count = cnt_left[3:0];
						nxt.next_chan  = cur.next_chan + 4'd1;
					end else begin
						nxt.pend_bits  = acc[9:0];
						nxt.pend_count = cnt[3:0];
					end
				end else begin
					// flags byte
					nxt.phase = PH_END;
					res.valid = 1'b1;
					res.rtype = RT_FLAGS;
					res.flags = {data_byte[6], data_byte[7]};
				end
			end
			PH_END: begin
				nxt.phase = PH_HUNT;
				res.valid = 1'b1;
				res.rtype = (data_byte == end_marker) ? RT_GOOD : RT_ERROR;
			end
			default: begin
				nxt.phase = PH_HUNT;
				if (data_byte == start_marker) begin
					nxt.phase      = PH_DATA;
					nxt.byte_count = '0;
					nxt.pend_bits  = '0;
					nxt.pend_count = '0;
					nxt.next_chan  = '0;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/sbus_frame_parser_core.sv =====
// Top level of the serial-bus frame parser: input stage, parse state, result register.
//
// Channel  Dir  Beat contents
// s_*      in   tdata[7:0] data_byte
// m_*      out  tuser[1:0] result_type; tdata: channel_index, channel_value, digital_flags
// cfg_*    in   index 0 start_marker, index 1 end_marker, data[7:0]
//
// One byte per cycle sustained while m_tready keeps results moving; an accepted byte is
// registered in the input stage, and its result in the result register, which drives m_tvalid.
// Parse state and both stages are cleared by arst_n; markers reset to F0 and 00.
// A stalled result holds the input stage and the parse state; s_tready stays high while the
// input stage is empty or moving on.
`timescale 1ns / 1ps
`default_nettype none

module sbus_frame_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output var  logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	output var  logic        m_tvalid,
	input  wire logic        m_tready,
	output var  logic [23:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value,
	                                    // [16:15] digital_flags, [23:17] zero
	output var  logic [1:0]  m_tuser,   // [1:0] result_type
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import sbfp_pkg::*;

	logic [7:0]   start_marker_q;
	logic [7:0]   end_marker_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      res_nxt;
	result_t      res_q;
	logic         advance;

	assign advance  = valid_s1 && (!res_q.valid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sbfp_step u_step (
		.cur          (state_q),
		.data_byte    (byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_HUNT;
			state_q.byte_count <= '0;
			state_q.pend_bits  <= '0;
			state_q.pend_count <= '0;
			state_q.next_chan  <= '0;
			res_q              <= '0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				res_q   <= res_nxt;
			end else if (m_tready) begin
				res_q.valid <= 1'b0;
			end
		end
	end

	assign m_tvalid = res_q.valid;
	assign m_tuser  = res_q.rtype;
	assign m_tdata  = {7'd0, res_q.flags, res_q.value, res_q.idx};

	// after the last data byte all sixteen channels are out and no bits remain
	a_frame_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.phase == PH_DATA && state_q.byte_count == DATA_BYTES)
		|-> (state_q.next_chan == 4'd0 && state_q.pend_count == 4'd0))
		else $error("channels or bits left over at flags byte");

	a_end_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.phase == PH_END) |=> state_q.phase == PH_HUNT)
		else $error("closing byte did not return to hunting");

	a_end_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_END)
		|-> ($past(state_q.phase) == PH_DATA || $past(state_q.phase) == PH_END))
		else $error("end phase entered without data phase");

endmodule

`default_nettype wire
